// File: hdl/vfa_pkg.sv
// Shared types, constants and helper functions for the four-element vector ALU.
// Used by every module in the hdl folder; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vfa_pkg;

    // Number formats and lane counts.
    localparam int FX_W     = 32;
    localparam int FRAC     = 16;
    localparam int NLANE    = 4;
    localparam int NMUL     = 6;
    localparam int PROD_W   = 2 * FX_W;
    localparam int WIDE_W   = 68;
    localparam int TOL_W    = 17;

    // Square root and divider pipeline sizes.
    localparam int SQ_STAGES = 32;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int DEN_W     = 32;
    localparam int NUM_W     = FX_W + FRAC;

    // Queue depths and pointer widths.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    // Configuration register map.
    localparam int                 PADDR_W        = 2;
    localparam logic [PADDR_W-1:0] ADDR_TOLERANCE = 2'd0;
    localparam logic [TOL_W-1:0]   TOL_RESET      = 17'd7;

    localparam logic [FX_W-1:0] FX_ONE = 32'h0001_0000;

    typedef logic signed [FX_W-1:0] fx_t;

    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_NEG      = 4'd2,
        ACT_SCALE    = 4'd3,
        ACT_DIV      = 4'd4,
        ACT_MAG      = 4'd5,
        ACT_NORM     = 4'd6,
        ACT_DOT      = 4'd7,
        ACT_CROSS    = 4'd8,
        ACT_HADAMARD = 4'd9,
        ACT_EQ       = 4'd10,
        ACT_ISPOINT  = 4'd11,
        ACT_ISVECTOR = 4'd12
    } action_t;

    typedef struct packed {
        logic [3:0] action;
        fx_t        a_x;
        fx_t        a_y;
        fx_t        a_z;
        fx_t        a_w;
        fx_t        b_x;
        fx_t        b_y;
        fx_t        b_z;
        fx_t        b_w;
        fx_t        scalar_in;
    } in_item_t;

    typedef struct packed {
        fx_t  r_x;
        fx_t  r_y;
        fx_t  r_z;
        fx_t  r_w;
        fx_t  scalar_out;
        logic test_true;
        logic status;
    } out_item_t;

    // Classified command from the front end.
    typedef struct packed {
        action_t                      op;
        logic [NLANE-1:0][FX_W-1:0]   a;
        logic [FX_W-1:0]              f;
        logic [NMUL-1:0][FX_W-1:0]    mx;
        logic [NMUL-1:0][FX_W-1:0]    my;
        logic [NLANE-1:0][FX_W-1:0]   r;
        logic                         test;
    } cmd_t;

    // Side information that rides along the square root pipeline.
    typedef struct packed {
        action_t                      op;
        logic [NLANE-1:0][FX_W-1:0]   a;
        logic [FX_W-1:0]              f;
        logic [NLANE-1:0][FX_W-1:0]   r;
        logic [FX_W-1:0]              s;
        logic                         test;
    } stag_t;

    // Side information that rides along the divider pipeline.
    typedef struct packed {
        logic                         use_q;
        logic                         status;
        logic                         test;
        logic [NLANE-1:0]             negq;
        logic [FX_W-1:0]              s;
        logic [NLANE-1:0][FX_W-1:0]   r;
    } dtag_t;

    // Sign-extend a Q16.16 word into the wide accumulation format.
    function automatic logic signed [WIDE_W-1:0] sx(input logic [FX_W-1:0] v);
        return {{(WIDE_W - FX_W){v[FX_W-1]}}, v};
    endfunction

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic fx_t sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] maxv;
        logic signed [WIDE_W-1:0] minv;
        maxv = {{(WIDE_W - FX_W + 1){1'b0}}, {(FX_W - 1){1'b1}}};
        minv = {{(WIDE_W - FX_W + 1){1'b1}}, {(FX_W - 1){1'b0}}};
        if (v > maxv) begin
            return {1'b0, {(FX_W - 1){1'b1}}};
        end
        if (v < minv) begin
            return {1'b1, {(FX_W - 1){1'b0}}};
        end
        return v[FX_W-1:0];
    endfunction

    // True when |x - y| is below the tolerance.
    function automatic logic near(input logic [FX_W-1:0] x, input logic [FX_W-1:0] y,
                                  input logic [TOL_W-1:0] tol);
        logic signed [FX_W:0] d;
        logic [FX_W:0]        ad;
        d  = $signed({x[FX_W-1], x}) - $signed({y[FX_W-1], y});
        ad = d[FX_W] ? (FX_W + 1)'(-d) : (FX_W + 1)'(d);
        return ad < (FX_W + 1)'(tol);
    endfunction

endpackage

`default_nettype wire

// File: hdl/vfa_front.sv
// Front end: accepts input items, decodes the action and selects multiplier operands.
// Also resolves add, subtract, negate and the tolerance tests. Depends on vfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfa_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire vfa_pkg::in_item_t          item,
    input  wire logic [vfa_pkg::TOL_W-1:0]  tolerance,
    output logic                            cmd_valid,
    input  wire logic                       cmd_ready,
    output vfa_pkg::cmd_t                   cmd
);

    logic          valid_reg;
    vfa_pkg::cmd_t cmd_reg;
    vfa_pkg::cmd_t cmd_next;
    logic          load;

    logic [vfa_pkg::NLANE-1:0][vfa_pkg::FX_W-1:0] av;
    logic [vfa_pkg::NLANE-1:0][vfa_pkg::FX_W-1:0] bv;

    // The holding register takes a new item when it is empty or drains this cycle.
    assign load      = !valid_reg || cmd_ready;
    assign full      = !load;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // Decode and classify the incoming item.
    always_comb
    begin
        av = {item.a_w, item.a_z, item.a_y, item.a_x};
        bv = {item.b_w, item.b_z, item.b_y, item.b_x};
        cmd_next      = '0;
        cmd_next.op   = vfa_pkg::action_t'(item.action);
        cmd_next.a    = av;
        cmd_next.f    = item.scalar_in;
        for (int i = 0; i < vfa_pkg::NLANE; i++)
        begin
            cmd_next.mx[i] = av[i];
            cmd_next.my[i] = bv[i];
        end
        cmd_next.mx[4] = av[0];
        cmd_next.my[4] = bv[0];
        cmd_next.mx[5] = av[1];
        cmd_next.my[5] = bv[1];

        unique case (cmd_next.op)
            vfa_pkg::ACT_ADD:
            begin
                for (int i = 0; i < vfa_pkg::NLANE; i++)
                    cmd_next.r[i] = vfa_pkg::sat32(vfa_pkg::sx(av[i]) + vfa_pkg::sx(bv[i]));
            end
            vfa_pkg::ACT_SUB:
            begin
                for (int i = 0; i < vfa_pkg::NLANE; i++)
                    cmd_next.r[i] = vfa_pkg::sat32(vfa_pkg::sx(av[i]) - vfa_pkg::sx(bv[i]));
            end
            vfa_pkg::ACT_NEG:
            begin
                for (int i = 0; i < vfa_pkg::NLANE; i++)
                    cmd_next.r[i] = vfa_pkg::sat32(-vfa_pkg::sx(av[i]));
            end
            vfa_pkg::ACT_SCALE:
            begin
                for (int i = 0; i < vfa_pkg::NLANE; i++)
                    cmd_next.my[i] = item.scalar_in;
            end
            vfa_pkg::ACT_MAG, vfa_pkg::ACT_NORM:
            begin
                for (int i = 0; i < vfa_pkg::NLANE; i++)
                    cmd_next.my[i] = av[i];
            end
            vfa_pkg::ACT_CROSS:
            begin
                // Products: y*z', z*y', z*x', x*z', x*y', y*x'.
                cmd_next.mx = {av[1], av[0], av[0], av[2], av[2], av[1]};
                cmd_next.my = {bv[0], bv[1], bv[2], bv[0], bv[1], bv[2]};
            end
            vfa_pkg::ACT_EQ:
            begin
                cmd_next.test = vfa_pkg::near(av[0], bv[0], tolerance)
                             && vfa_pkg::near(av[1], bv[1], tolerance)
                             && vfa_pkg::near(av[2], bv[2], tolerance)
                             && vfa_pkg::near(av[3], bv[3], tolerance);
            end
            vfa_pkg::ACT_ISPOINT:
            begin
                cmd_next.test = vfa_pkg::near(av[3], vfa_pkg::FX_ONE, tolerance);
            end
            vfa_pkg::ACT_ISVECTOR:
            begin
                cmd_next.test = vfa_pkg::near(av[3], '0, tolerance);
            end
            default:
            begin
            end
        endcase
    end

    // Holding register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= push;
        end
    end

    // Holding register payload.
    always_ff @(posedge clk)
    begin
        if (load && push)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/vfa_cmdq.sv
// Short command queue between the front end and the execution pipeline.
// Holds classified commands; depends on vfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfa_cmdq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire vfa_pkg::cmd_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output vfa_pkg::cmd_t      rd_data
);

    vfa_pkg::cmd_t                 mem [vfa_pkg::CMDQ_DEPTH];
    logic [vfa_pkg::CMDQ_AW-1:0]   wptr_reg;
    logic [vfa_pkg::CMDQ_AW-1:0]   rptr_reg;
    logic [vfa_pkg::CMDQ_CW-1:0]   count_reg;
    logic                          wr_en;
    logic                          rd_en;

    assign wr_ready = count_reg != vfa_pkg::CMDQ_CW'(vfa_pkg::CMDQ_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= (wptr_reg == vfa_pkg::CMDQ_AW'(vfa_pkg::CMDQ_DEPTH - 1))
                            ? '0 : wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= (rptr_reg == vfa_pkg::CMDQ_AW'(vfa_pkg::CMDQ_DEPTH - 1))
                            ? '0 : rptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/vfa_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side tag.
// Depends on vfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfa_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic [vfa_pkg::RAD_W-1:0]    rad,
    input  wire vfa_pkg::stag_t               in_tag,
    output logic                              out_valid,
    output logic [vfa_pkg::ROOT_W-1:0]        root,
    output vfa_pkg::stag_t                    out_tag
);

    logic                        valid_reg [vfa_pkg::SQ_STAGES];
    logic [vfa_pkg::RAD_W-1:0]   num_reg   [vfa_pkg::SQ_STAGES];
    logic [vfa_pkg::RAD_W-1:0]   res_reg   [vfa_pkg::SQ_STAGES];
    vfa_pkg::stag_t              tag_reg   [vfa_pkg::SQ_STAGES];

    for (genvar k = 0; k < vfa_pkg::SQ_STAGES; k++)
    begin : g_stage
        localparam logic [vfa_pkg::RAD_W-1:0] BIT =
            vfa_pkg::RAD_W'(1) << (2 * (vfa_pkg::SQ_STAGES - 1 - k));

        logic                      v_src;
        logic [vfa_pkg::RAD_W-1:0] num_src;
        logic [vfa_pkg::RAD_W-1:0] res_src;
        vfa_pkg::stag_t            tag_src;
        logic [vfa_pkg::RAD_W-1:0] trial;
        logic [vfa_pkg::RAD_W-1:0] num_next;
        logic [vfa_pkg::RAD_W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign v_src   = in_valid;
            assign num_src = rad;
            assign res_src = '0;
            assign tag_src = in_tag;
        end
        else
        begin : g_rest
            assign v_src   = valid_reg[k-1];
            assign num_src = num_reg[k-1];
            assign res_src = res_reg[k-1];
            assign tag_src = tag_reg[k-1];
        end

        // One step of the digit-by-digit root.
        always_comb
        begin
            trial = res_src + BIT;
            if (num_src >= trial)
            begin
                num_next = num_src - trial;
                res_next = (res_src >> 1) + BIT;
            end
            else
            begin
                num_next = num_src;
                res_next = res_src >> 1;
            end
        end

        // Stage valid flag.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= v_src;
            end
        end

        // Stage payload.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[k] <= num_next;
                res_reg[k] <= res_next;
                tag_reg[k] <= tag_src;
            end
        end
    end

    assign out_valid = valid_reg[vfa_pkg::SQ_STAGES-1];
    assign root      = res_reg[vfa_pkg::SQ_STAGES-1][vfa_pkg::ROOT_W-1:0];
    assign out_tag   = tag_reg[vfa_pkg::SQ_STAGES-1];

endmodule

`default_nettype wire

// File: hdl/vfa_div.sv
// Pipelined restoring divider for four lanes sharing one divisor, one quotient
// bit per stage, with a side tag. Depends on vfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfa_div (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           adv,
    input  wire logic                                           in_valid,
    input  wire logic [vfa_pkg::DEN_W-1:0]                      den,
    input  wire logic [vfa_pkg::NLANE-1:0][vfa_pkg::NUM_W-1:0]  num,
    input  wire vfa_pkg::dtag_t                                 in_tag,
    output logic                                                out_valid,
    output logic [vfa_pkg::NLANE-1:0][vfa_pkg::NUM_W-1:0]       quo,
    output vfa_pkg::dtag_t                                      out_tag
);

    logic                                             valid_reg [vfa_pkg::NUM_W];
    logic [vfa_pkg::DEN_W-1:0]                        den_reg   [vfa_pkg::NUM_W];
    logic [vfa_pkg::NLANE-1:0][vfa_pkg::DEN_W-1:0]    rem_reg   [vfa_pkg::NUM_W];
    logic [vfa_pkg::NLANE-1:0][vfa_pkg::NUM_W-1:0]    nq_reg    [vfa_pkg::NUM_W];
    vfa_pkg::dtag_t                                   tag_reg   [vfa_pkg::NUM_W];

    for (genvar k = 0; k < vfa_pkg::NUM_W; k++)
    begin : g_stage
        logic                                          v_src;
        logic [vfa_pkg::DEN_W-1:0]                     den_src;
        logic [vfa_pkg::NLANE-1:0][vfa_pkg::DEN_W-1:0] rem_src;
        logic [vfa_pkg::NLANE-1:0][vfa_pkg::NUM_W-1:0] nq_src;
        vfa_pkg::dtag_t                                tag_src;
        logic [vfa_pkg::NLANE-1:0][vfa_pkg::DEN_W-1:0] rem_next;
        logic [vfa_pkg::NLANE-1:0][vfa_pkg::NUM_W-1:0] nq_next;
        logic [vfa_pkg::DEN_W:0]                       shifted;
        logic [vfa_pkg::DEN_W:0]                       diff;

        if (k == 0)
        begin : g_first
            assign v_src   = in_valid;
            assign den_src = den;
            assign rem_src = '0;
            assign nq_src  = num;
            assign tag_src = in_tag;
        end
        else
        begin : g_rest
            assign v_src   = valid_reg[k-1];
            assign den_src = den_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign nq_src  = nq_reg[k-1];
            assign tag_src = tag_reg[k-1];
        end

        // Shift in the next numerator bit and try the subtraction in every lane.
        always_comb
        begin
            shifted = '0;
            diff    = '0;
            for (int i = 0; i < vfa_pkg::NLANE; i++)
            begin
                shifted = {rem_src[i], nq_src[i][vfa_pkg::NUM_W-1]};
                diff    = shifted - {1'b0, den_src};
                if (shifted >= {1'b0, den_src})
                begin
                    rem_next[i] = diff[vfa_pkg::DEN_W-1:0];
                    nq_next[i]  = {nq_src[i][vfa_pkg::NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = shifted[vfa_pkg::DEN_W-1:0];
                    nq_next[i]  = {nq_src[i][vfa_pkg::NUM_W-2:0], 1'b0};
                end
            end
        end

        // Stage valid flag.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= v_src;
            end
        end

        // Stage payload.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[k] <= den_src;
                rem_reg[k] <= rem_next;
                nq_reg[k]  <= nq_next;
                tag_reg[k] <= tag_src;
            end
        end
    end

    assign out_valid = valid_reg[vfa_pkg::NUM_W-1];
    assign quo       = nq_reg[vfa_pkg::NUM_W-1];
    assign out_tag   = tag_reg[vfa_pkg::NUM_W-1];

endmodule

`default_nettype wire

// File: hdl/vfa_back.sv
// Execution pipeline: multiply, accumulate, square root, divide, finish, and the
// result queue. Depends on vfa_pkg, vfa_sqrt and vfa_div.
`timescale 1ns / 1ps
`default_nettype none

module vfa_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire vfa_pkg::cmd_t      cmd,
    output logic                    empty,
    input  wire logic               pop,
    output vfa_pkg::out_item_t      result
);

    logic adv;

    // Multiply stage registers.
    logic                                              m_valid_reg;
    vfa_pkg::cmd_t                                     m_cmd_reg;
    logic signed [vfa_pkg::PROD_W-1:0]                 prod_reg [vfa_pkg::NMUL];

    // Accumulate stage registers.
    logic                                              a_valid_reg;
    vfa_pkg::stag_t                                    a_tag_reg;
    logic [vfa_pkg::RAD_W-1:0]                         rad_reg;
    vfa_pkg::stag_t                                    a_tag_next;
    logic [vfa_pkg::RAD_W-1:0]                         rad_next;
    logic signed [vfa_pkg::WIDE_W-1:0]                 pw [vfa_pkg::NMUL];
    logic signed [vfa_pkg::WIDE_W-1:0]                 sum4;
    logic [vfa_pkg::RAD_W+1:0]                         sqsum;

    // Square root outputs.
    logic                                              sq_valid;
    logic [vfa_pkg::ROOT_W-1:0]                        sq_root;
    vfa_pkg::stag_t                                    sq_tag;

    // Divider setup stage registers.
    logic                                              s_valid_reg;
    logic [vfa_pkg::DEN_W-1:0]                         den_reg;
    logic [vfa_pkg::NLANE-1:0][vfa_pkg::NUM_W-1:0]     num_reg;
    vfa_pkg::dtag_t                                    s_tag_reg;
    logic [vfa_pkg::DEN_W-1:0]                         den_next;
    logic [vfa_pkg::NLANE-1:0][vfa_pkg::NUM_W-1:0]     num_next;
    vfa_pkg::dtag_t                                    s_tag_next;
    logic [vfa_pkg::FX_W-1:0]                          abs_a;
    logic [vfa_pkg::FX_W-1:0]                          abs_f;

    // Divider outputs.
    logic                                              dv_valid;
    logic [vfa_pkg::NLANE-1:0][vfa_pkg::NUM_W-1:0]     dv_quo;
    vfa_pkg::dtag_t                                    dv_tag;

    // Finish stage registers.
    logic                                              fin_valid_reg;
    vfa_pkg::out_item_t                                fin_item_reg;
    vfa_pkg::out_item_t                                fin_item_next;
    logic [vfa_pkg::NLANE-1:0][vfa_pkg::FX_W-1:0]      fin_r;
    logic signed [vfa_pkg::WIDE_W-1:0]                 qw;

    // Result queue.
    vfa_pkg::out_item_t                                rq_mem [vfa_pkg::RESQ_DEPTH];
    logic [vfa_pkg::RESQ_AW-1:0]                       rq_wptr_reg;
    logic [vfa_pkg::RESQ_AW-1:0]                       rq_rptr_reg;
    logic [vfa_pkg::RESQ_CW-1:0]                       rq_count_reg;
    logic                                              rq_full;
    logic                                              rq_push;
    logic                                              rq_pop;

    // The whole pipeline moves unless the finished item cannot enter the queue.
    assign rq_full   = rq_count_reg == vfa_pkg::RESQ_CW'(vfa_pkg::RESQ_DEPTH);
    assign adv       = !(fin_valid_reg && rq_full);
    assign cmd_ready = adv;
    assign rq_push   = fin_valid_reg && !rq_full;
    assign empty     = rq_count_reg == '0;
    assign rq_pop    = pop && !empty;
    assign result    = rq_mem[rq_rptr_reg];

    // Multiply stage: six signed 32x32 products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_cmd_reg <= cmd;
            for (int i = 0; i < vfa_pkg::NMUL; i++)
            begin
                prod_reg[i] <= $signed(cmd.mx[i]) * $signed(cmd.my[i]);
            end
        end
    end

    // Accumulate stage: rescale products and build the radicand.
    always_comb
    begin
        for (int i = 0; i < vfa_pkg::NMUL; i++)
        begin
            pw[i] = {{(vfa_pkg::WIDE_W - vfa_pkg::PROD_W){prod_reg[i][vfa_pkg::PROD_W-1]}},
                     prod_reg[i]};
        end
        sum4  = pw[0] + pw[1] + pw[2] + pw[3];
        sqsum = {2'b00, prod_reg[0]} + {2'b00, prod_reg[1]}
              + {2'b00, prod_reg[2]} + {2'b00, prod_reg[3]};

        a_tag_next      = '0;
        a_tag_next.op   = m_cmd_reg.op;
        a_tag_next.a    = m_cmd_reg.a;
        a_tag_next.f    = m_cmd_reg.f;
        a_tag_next.r    = m_cmd_reg.r;
        a_tag_next.test = m_cmd_reg.test;
        rad_next        = '0;

        unique case (m_cmd_reg.op)
            vfa_pkg::ACT_SCALE:
            begin
                for (int i = 0; i < vfa_pkg::NLANE; i++)
                    a_tag_next.r[i] = vfa_pkg::sat32(pw[i] >>> vfa_pkg::FRAC);
            end
            vfa_pkg::ACT_HADAMARD:
            begin
                for (int i = 0; i < vfa_pkg::NLANE - 1; i++)
                    a_tag_next.r[i] = vfa_pkg::sat32(pw[i] >>> vfa_pkg::FRAC);
            end
            vfa_pkg::ACT_DOT:
            begin
                a_tag_next.s = vfa_pkg::sat32(sum4 >>> vfa_pkg::FRAC);
            end
            vfa_pkg::ACT_CROSS:
            begin
                a_tag_next.r[0] = vfa_pkg::sat32((pw[0] - pw[1]) >>> vfa_pkg::FRAC);
                a_tag_next.r[1] = vfa_pkg::sat32((pw[2] - pw[3]) >>> vfa_pkg::FRAC);
                a_tag_next.r[2] = vfa_pkg::sat32((pw[4] - pw[5]) >>> vfa_pkg::FRAC);
            end
            vfa_pkg::ACT_MAG, vfa_pkg::ACT_NORM:
            begin
                // A sum past 64 bits pins at the all-ones radicand.
                rad_next = (sqsum[vfa_pkg::RAD_W+1:vfa_pkg::RAD_W] != 2'b00)
                           ? '1 : sqsum[vfa_pkg::RAD_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_tag_reg <= a_tag_next;
            rad_reg   <= rad_next;
        end
    end

    // Magnitude.
    vfa_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (a_valid_reg),
        .rad       (rad_reg),
        .in_tag    (a_tag_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_tag   (sq_tag)
    );

    // Divider setup: pick the divisor, split signs and detect a zero divisor.
    always_comb
    begin
        s_tag_next      = '0;
        s_tag_next.test = sq_tag.test;
        s_tag_next.s    = sq_tag.s;
        s_tag_next.r    = sq_tag.r;
        den_next        = sq_root;
        abs_a           = '0;
        abs_f           = sq_tag.f[vfa_pkg::FX_W-1] ? vfa_pkg::FX_W'(-sq_tag.f) : sq_tag.f;
        for (int i = 0; i < vfa_pkg::NLANE; i++)
        begin
            abs_a = sq_tag.a[i][vfa_pkg::FX_W-1] ? vfa_pkg::FX_W'(-sq_tag.a[i]) : sq_tag.a[i];
            num_next[i] = {abs_a, {vfa_pkg::FRAC{1'b0}}};
        end

        unique case (sq_tag.op)
            vfa_pkg::ACT_MAG:
            begin
                s_tag_next.s = vfa_pkg::sat32({{(vfa_pkg::WIDE_W - vfa_pkg::ROOT_W){1'b0}},
                                               sq_root});
            end
            vfa_pkg::ACT_NORM:
            begin
                if (sq_root == '0)
                begin
                    s_tag_next.status = 1'b1;
                end
                else
                begin
                    s_tag_next.use_q = 1'b1;
                    for (int i = 0; i < vfa_pkg::NLANE; i++)
                        s_tag_next.negq[i] = sq_tag.a[i][vfa_pkg::FX_W-1];
                end
            end
            vfa_pkg::ACT_DIV:
            begin
                den_next = abs_f;
                if (sq_tag.f == '0)
                begin
                    s_tag_next.status = 1'b1;
                end
                else
                begin
                    s_tag_next.use_q = 1'b1;
                    for (int i = 0; i < vfa_pkg::NLANE; i++)
                        s_tag_next.negq[i] = sq_tag.a[i][vfa_pkg::FX_W-1]
                                           ^ sq_tag.f[vfa_pkg::FX_W-1];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg   <= den_next;
            num_reg   <= num_next;
            s_tag_reg <= s_tag_next;
        end
    end

    // Quotients for divide and normalize.
    vfa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_valid_reg),
        .den       (den_reg),
        .num       (num_reg),
        .in_tag    (s_tag_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_tag   (dv_tag)
    );

    // Finish stage: apply quotient signs and saturate.
    always_comb
    begin
        fin_r = dv_tag.r;
        qw    = '0;
        if (dv_tag.use_q)
        begin
            for (int i = 0; i < vfa_pkg::NLANE; i++)
            begin
                qw = $signed({{(vfa_pkg::WIDE_W - vfa_pkg::NUM_W){1'b0}}, dv_quo[i]});
                fin_r[i] = vfa_pkg::sat32(dv_tag.negq[i] ? -qw : qw);
            end
        end
        fin_item_next.r_x        = fin_r[0];
        fin_item_next.r_y        = fin_r[1];
        fin_item_next.r_z        = fin_r[2];
        fin_item_next.r_w        = fin_r[3];
        fin_item_next.scalar_out = dv_tag.s;
        fin_item_next.test_true  = dv_tag.test;
        fin_item_next.status     = dv_tag.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fin_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_item_reg <= fin_item_next;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wptr_reg  <= '0;
            rq_rptr_reg  <= '0;
            rq_count_reg <= '0;
        end
        else
        begin
            if (rq_push)
            begin
                rq_wptr_reg <= (rq_wptr_reg == vfa_pkg::RESQ_AW'(vfa_pkg::RESQ_DEPTH - 1))
                               ? '0 : rq_wptr_reg + 1'b1;
            end
            if (rq_pop)
            begin
                rq_rptr_reg <= (rq_rptr_reg == vfa_pkg::RESQ_AW'(vfa_pkg::RESQ_DEPTH - 1))
                               ? '0 : rq_rptr_reg + 1'b1;
            end
            if (rq_push && !rq_pop)
            begin
                rq_count_reg <= rq_count_reg + 1'b1;
            end
            else if (rq_pop && !rq_push)
            begin
                rq_count_reg <= rq_count_reg - 1'b1;
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_mem[rq_wptr_reg] <= fin_item_reg;
        end
    end

`ifndef SYNTHESIS
    // The result queue never holds more than its depth.
    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_count_reg <= vfa_pkg::RESQ_CW'(vfa_pkg::RESQ_DEPTH))
        else $error("result queue overfilled");

    // A finished item held by a stall stays in place unchanged.
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !adv |=> fin_valid_reg && $stable(fin_item_reg))
        else $error("finished item lost during stall");

    // A zero-divisor status always comes with a zero tuple and no test bit.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && fin_item_reg.status |->
            fin_item_reg.r_x == '0 && fin_item_reg.r_y == '0 &&
            fin_item_reg.r_z == '0 && fin_item_reg.r_w == '0 && !fin_item_reg.test_true)
        else $error("status set with nonzero result");

    // A stalled multiply stage keeps its item.
    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !adv |=> m_valid_reg)
        else $error("multiply stage dropped an item");
`endif

endmodule

`default_nettype wire

// File: hdl/four_element_vector_alu.sv
// Top level of the four-element vector ALU: tolerance register on the APB port,
// front end, command queue and execution pipeline. Depends on vfa_pkg and all vfa_ modules.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Items enter through a queue-style port: drive item and raise push; the item
// transfers at a rising edge where push is high and full is low. Results leave
// the same way: while empty is low the oldest result sits on result, and it
// transfers at a rising edge where pop is high.
// Throughput is one item per cycle when nothing stalls. Every item takes the same
// path through a multiply stage, an accumulate stage, a 32-stage square root, a
// setup stage, a 48-stage divider (one quotient bit per stage) and a finish stage.
// When the receiver stops popping, the two-entry result queue fills, the whole
// execution pipeline freezes in place, the command queue fills and full rises;
// no item is dropped. The tolerance register (byte address 0) is written through
// the APB port; the user must write it only while the block is idle, and the
// block itself does not enforce this.
// Reset clears all valid flags and queues and sets the tolerance to 7.

module four_element_vector_alu (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire vfa_pkg::in_item_t             item,
    output logic                               empty,
    input  wire logic                          pop,
    output vfa_pkg::out_item_t                 result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vfa_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [vfa_pkg::TOL_W-1:0] tol_reg;
    logic                      cfg_wr;
    logic                      f_valid;
    logic                      f_ready;
    vfa_pkg::cmd_t             f_cmd;
    logic                      q_valid;
    logic                      q_ready;
    vfa_pkg::cmd_t             q_cmd;

    // Register port: writes land in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == vfa_pkg::ADDR_TOLERANCE);
    assign prdata = (paddr == vfa_pkg::ADDR_TOLERANCE)
                    ? {{(32 - vfa_pkg::TOL_W){1'b0}}, tol_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= vfa_pkg::TOL_RESET;
        end
        else if (cfg_wr)
        begin
            tol_reg <= pwdata[vfa_pkg::TOL_W-1:0];
        end
    end

    vfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .tolerance (tol_reg),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    vfa_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    vfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

// File: sim/tb_four_element_vector_alu.sv
// Self-checking testbench for the four-element vector ALU.
// Directed table and random items run against a built-in predictor; depends on vfa_pkg.
`timescale 1ns / 1ps

module tb_four_element_vector_alu;

    localparam int LATENCY     = 86;
    localparam int CYCLE_LIMIT = 600000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    vfa_pkg::in_item_t           item = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    vfa_pkg::out_item_t          result;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [vfa_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    four_element_vector_alu u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always #6 clk = ~clk;

    // Predictor state and the queue of expected results.
    logic [vfa_pkg::TOL_W-1:0] tol_model = vfa_pkg::TOL_RESET;
    vfa_pkg::out_item_t        pending_results[$];
    int                        errors = 0;
    int                        cycles = 0;
    int                        checked = 0;
    int                        send_idle_pct = 0;
    int                        recv_stall_pct = 0;

    // Directed rows: item plus an optional hand-typed expectation.
    typedef struct {
        vfa_pkg::in_item_t  stim;
        logic               has_exp;
        vfa_pkg::out_item_t exp_res;
    } directed_row_t;

    localparam vfa_pkg::fx_t MAXV = 32'sh7fffffff;
    localparam vfa_pkg::fx_t MINV = 32'sh80000000;

    function automatic logic signed [127:0] floor_q16(input logic signed [127:0] v);
        return v >>> 16;
    endfunction

    function automatic vfa_pkg::fx_t sat_wide(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return MAXV;
        if (v < -128'sd2147483648) return MINV;
        return v[31:0];
    endfunction

    function automatic logic within_tol(input vfa_pkg::fx_t x, input vfa_pkg::fx_t y);
        logic signed [33:0] d;
        d = $signed({{2{x[31]}}, x}) - $signed({{2{y[31]}}, y});
        if (d < 0) d = -d;
        return d < $signed({17'd0, tol_model});
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] num);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > num) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (num >= res + bitv)
            begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Quotient of (a << 16) / d, truncated toward zero, saturated.
    function automatic vfa_pkg::fx_t fx_quot(input vfa_pkg::fx_t a,
                                             input logic signed [127:0] d);
        logic signed [127:0] n;
        n = $signed(a) * 128'sd65536;
        return sat_wide(n / d);
    endfunction

    function automatic vfa_pkg::out_item_t alu_predict(input vfa_pkg::in_item_t it);
        vfa_pkg::out_item_t  o;
        vfa_pkg::fx_t        a[4];
        vfa_pkg::fx_t        b[4];
        logic signed [127:0] wa[4];
        logic signed [127:0] wb[4];
        logic signed [127:0] acc;
        logic [64:0]         sumsq;
        logic [63:0]         root;
        o = '0;
        a = '{it.a_x, it.a_y, it.a_z, it.a_w};
        b = '{it.b_x, it.b_y, it.b_z, it.b_w};
        for (int i = 0; i < 4; i++)
        begin
            wa[i] = $signed(a[i]);
            wb[i] = $signed(b[i]);
        end
        case (it.action)
            vfa_pkg::ACT_ADD:
            begin
                o.r_x = sat_wide(wa[0] + wb[0]); o.r_y = sat_wide(wa[1] + wb[1]);
                o.r_z = sat_wide(wa[2] + wb[2]); o.r_w = sat_wide(wa[3] + wb[3]);
            end
            vfa_pkg::ACT_SUB:
            begin
                o.r_x = sat_wide(wa[0] - wb[0]); o.r_y = sat_wide(wa[1] - wb[1]);
                o.r_z = sat_wide(wa[2] - wb[2]); o.r_w = sat_wide(wa[3] - wb[3]);
            end
            vfa_pkg::ACT_NEG:
            begin
                o.r_x = sat_wide(-wa[0]); o.r_y = sat_wide(-wa[1]);
                o.r_z = sat_wide(-wa[2]); o.r_w = sat_wide(-wa[3]);
            end
            vfa_pkg::ACT_SCALE:
            begin
                acc = $signed(it.scalar_in);
                o.r_x = sat_wide(floor_q16(wa[0] * acc));
                o.r_y = sat_wide(floor_q16(wa[1] * acc));
                o.r_z = sat_wide(floor_q16(wa[2] * acc));
                o.r_w = sat_wide(floor_q16(wa[3] * acc));
            end
            vfa_pkg::ACT_DIV:
            begin
                if (it.scalar_in == 0)
                begin
                    o.status = 1'b1;
                end
                else
                begin
                    acc = $signed(it.scalar_in);
                    o.r_x = fx_quot(a[0], acc); o.r_y = fx_quot(a[1], acc);
                    o.r_z = fx_quot(a[2], acc); o.r_w = fx_quot(a[3], acc);
                end
            end
            vfa_pkg::ACT_MAG, vfa_pkg::ACT_NORM:
            begin
                // Four squares of the most negative value reach 2^64; such a sum
                // pins at the all-ones radicand.
                sumsq = 0;
                for (int i = 0; i < 4; i++) sumsq = sumsq + 65'(wa[i] * wa[i]);
                root = root_floor(sumsq[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sumsq[63:0]);
                if (it.action == vfa_pkg::ACT_MAG)
                begin
                    o.scalar_out = sat_wide($signed({64'd0, root}));
                end
                else if (root == 0)
                begin
                    o.status = 1'b1;
                end
                else
                begin
                    acc = $signed({64'd0, root});
                    o.r_x = fx_quot(a[0], acc); o.r_y = fx_quot(a[1], acc);
                    o.r_z = fx_quot(a[2], acc); o.r_w = fx_quot(a[3], acc);
                end
            end
            vfa_pkg::ACT_DOT:
            begin
                acc = wa[0] * wb[0] + wa[1] * wb[1] + wa[2] * wb[2] + wa[3] * wb[3];
                o.scalar_out = sat_wide(floor_q16(acc));
            end
            vfa_pkg::ACT_CROSS:
            begin
                o.r_x = sat_wide(floor_q16(wa[1] * wb[2] - wb[1] * wa[2]));
                o.r_y = sat_wide(floor_q16(wb[0] * wa[2] - wa[0] * wb[2]));
                o.r_z = sat_wide(floor_q16(wa[0] * wb[1] - wb[0] * wa[1]));
            end
            vfa_pkg::ACT_HADAMARD:
            begin
                o.r_x = sat_wide(floor_q16(wa[0] * wb[0]));
                o.r_y = sat_wide(floor_q16(wa[1] * wb[1]));
                o.r_z = sat_wide(floor_q16(wa[2] * wb[2]));
            end
            vfa_pkg::ACT_EQ:
                o.test_true = within_tol(a[0], b[0]) && within_tol(a[1], b[1]) &&
                              within_tol(a[2], b[2]) && within_tol(a[3], b[3]);
            vfa_pkg::ACT_ISPOINT: o.test_true = within_tol(a[3], vfa_pkg::FX_ONE);
            vfa_pkg::ACT_ISVECTOR: o.test_true = within_tol(a[3], 32'sd0);
            default: o = '0;
        endcase
        return o;
    endfunction

    // Cycle counter with timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls on pop and a check of every result transfer.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors <= errors + 1;
            end
            else
            begin
                if (result !== pending_results[0])
                begin
                    $display("%0t: mismatch expected %h actual %h", $time,
                             pending_results[0], result);
                    errors <= errors + 1;
                end
                void'(pending_results.pop_front());
                checked <= checked + 1;
            end
        end
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic apb_write(input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= vfa_pkg::ADDR_TOLERANCE; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        tol_model = value[vfa_pkg::TOL_W-1:0];
    endtask

    // Sends one item, with a random gap before it, and records its expectation.
    task automatic send_item(input vfa_pkg::in_item_t it, input logic has_exp,
                             input vfa_pkg::out_item_t ex);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        pending_results.push_back(has_exp ? ex : alu_predict(it));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic vfa_pkg::fx_t rand_fx();
        case ($urandom_range(5))
            0: return vfa_pkg::fx_t'($urandom_range(8)) - 4;
            1: return MAXV - vfa_pkg::fx_t'($urandom_range(3));
            2: return MINV + vfa_pkg::fx_t'($urandom_range(3));
            3: return vfa_pkg::fx_t'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            default: return vfa_pkg::fx_t'($urandom);
        endcase
    endfunction

    function automatic vfa_pkg::in_item_t rand_item();
        vfa_pkg::in_item_t it;
        it.action = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 13))
                                               : 4'($urandom_range(12));
        it.a_x = rand_fx(); it.a_y = rand_fx(); it.a_z = rand_fx(); it.a_w = rand_fx();
        it.b_x = rand_fx(); it.b_y = rand_fx(); it.b_z = rand_fx(); it.b_w = rand_fx();
        it.scalar_in = rand_fx();
        // Tests get near-equal operands so both outcomes show up.
        if (it.action == vfa_pkg::ACT_EQ && $urandom_range(1))
        begin
            it.b_x = it.a_x + vfa_pkg::fx_t'($urandom_range(16)) - 8;
            it.b_y = it.a_y; it.b_z = it.a_z;
            it.b_w = it.a_w - vfa_pkg::fx_t'($urandom_range(16)) + 8;
        end
        if ((it.action == vfa_pkg::ACT_ISPOINT || it.action == vfa_pkg::ACT_ISVECTOR)
            && $urandom_range(1))
            it.a_w = ((it.action == vfa_pkg::ACT_ISPOINT) ? vfa_pkg::FX_ONE : 32'sd0)
                     + vfa_pkg::fx_t'($urandom_range(16)) - 8;
        if (it.action == vfa_pkg::ACT_NORM && $urandom_range(9) == 0)
        begin
            it.a_x = 0; it.a_y = 0; it.a_z = 0; it.a_w = 0;
        end
        if (it.action == vfa_pkg::ACT_DIV && $urandom_range(9) == 0) it.scalar_in = 0;
        return it;
    endfunction

    function automatic vfa_pkg::in_item_t mk(input logic [3:0] act, input vfa_pkg::fx_t av,
                                             input vfa_pkg::fx_t bv, input vfa_pkg::fx_t s);
        vfa_pkg::in_item_t it;
        it = '{act, av, av, av, av, bv, bv, bv, bv, s};
        return it;
    endfunction

    function automatic vfa_pkg::out_item_t tup(input vfa_pkg::fx_t v, input logic st);
        vfa_pkg::out_item_t o;
        o = '{v, v, v, v, 32'sd0, 1'b0, st};
        return o;
    endfunction

    initial
    begin
        directed_row_t      rows[$];
        vfa_pkg::out_item_t none;
        int                 phase_idle[4];
        int                 phase_stall[4];
        logic [31:0]        tol_set[4];
        none = '0;
        phase_idle = '{0, 58, 0, 26};
        phase_stall = '{0, 0, 58, 26};
        tol_set = '{32'd0, 32'd65536, 32'd7, 32'h0001_ffff};

        // Directed table: extremes, every action, zero divisors, an unknown code.
        rows.push_back('{mk(vfa_pkg::ACT_ADD, MAXV, MAXV, 0), 1'b1, tup(MAXV, 1'b0)});
        rows.push_back('{mk(vfa_pkg::ACT_ADD, MINV, MINV, 0), 1'b1, tup(MINV, 1'b0)});
        rows.push_back('{mk(vfa_pkg::ACT_SUB, MINV, MAXV, 0), 1'b1, tup(MINV, 1'b0)});
        rows.push_back('{mk(vfa_pkg::ACT_NEG, MINV, 0, 0), 1'b1, tup(MAXV, 1'b0)});
        rows.push_back('{mk(vfa_pkg::ACT_SCALE, MAXV, 0, MAXV), 1'b1, tup(MAXV, 1'b0)});
        rows.push_back('{mk(vfa_pkg::ACT_SCALE, MINV, 0, MINV), 1'b1, tup(MAXV, 1'b0)});
        rows.push_back('{mk(vfa_pkg::ACT_SCALE, -3, 0, 1), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_DIV, 32'sh12345678, 0, 0), 1'b1, tup(0, 1'b1)});
        rows.push_back('{mk(vfa_pkg::ACT_DIV, MINV, 0, -1), 1'b1, tup(MAXV, 1'b0)});
        rows.push_back('{mk(vfa_pkg::ACT_DIV, -7, 0, 3), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_MAG, MINV, 0, 0), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_MAG, MAXV, 0, 0), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_NORM, 0, 0, 0), 1'b1, tup(0, 1'b1)});
        rows.push_back('{mk(vfa_pkg::ACT_NORM, MINV, 0, 0), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_NORM, 1, 0, 0), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_DOT, MINV, MINV, 0), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_DOT, MAXV, MINV, 0), 1'b0, none});
        rows.push_back('{'{vfa_pkg::ACT_CROSS, 32'sh10000, 0, 0, 5, 0, 32'sh10000, 0, 9, 0},
                         1'b0, none});
        rows.push_back('{'{vfa_pkg::ACT_CROSS, MINV, MAXV, MINV, 1, MAXV, MINV, MAXV, 1, 0},
                         1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_HADAMARD, MINV, MINV, 0), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_EQ, MAXV, MINV, 0), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_EQ, 100, 106, 0), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_ISPOINT, vfa_pkg::FX_ONE, 0, 0), 1'b0, none});
        rows.push_back('{mk(vfa_pkg::ACT_ISVECTOR, 7, 0, 0), 1'b0, none});
        rows.push_back('{'{4'd15, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV},
                         1'b1, none});

        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset tolerance.
        foreach (rows[i]) send_item(rows[i].stim, rows[i].has_exp, rows[i].exp_res);
        drain();

        // Random phases, each with its own tolerance and idling mix.
        for (int ph = 0; ph < 4; ph++)
        begin
            apb_write(tol_set[ph]);
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int n = 0; n < 290; n++) send_item(rand_item(), 1'b0, none);
            drain();
        end

        $display("Ran the directed table and %0d checked results over four tolerance", checked);
        $display("settings, with sender gaps and receiver stalls mixed in.");
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
